FILE: hw/rtl/fpr_pkg.sv
// Shared types and constants of the fast-packet reassembler.
package fpr_pkg;

  typedef struct packed {
    logic [7:0]  src_addr;
    logic [17:0] group_number;
    logic [3:0]  byte_count;
    logic [31:0] time_ms;
    logic [7:0]  byte_0;
    logic [7:0]  byte_1;
    logic [7:0]  byte_2;
    logic [7:0]  byte_3;
    logic [7:0]  byte_4;
    logic [7:0]  byte_5;
    logic [7:0]  byte_6;
    logic [7:0]  byte_7;
  } frame_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  msg_source;
    logic [17:0] msg_group;
    logic [7:0]  msg_length;
    logic [4:0]  word_index;
    logic [63:0] data_word;
    logic        last;
    logic [31:0] dropped_total;
  } result_t;

  localparam logic [1:0] ST_OPEN     = 2'd0;
  localparam logic [1:0] ST_WORD     = 2'd1;
  localparam logic [1:0] ST_REJECTED = 2'd2;
  localparam logic [1:0] ST_SHORT    = 2'd3;

  localparam logic [15:0] TIMEOUT_RESET = 16'd2000;

endpackage

FILE: hw/rtl/fpr_front.sv
// Front end: frame queue that decouples frame intake from session processing.
module fpr_front import fpr_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  output logic   full,
  input  frame_t frame,
  output logic   avail,
  input  logic   take,
  output frame_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  frame_t           mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_push;
  logic             do_take;

  assign full    = (count == (AW+1)'(DEPTH));
  assign avail   = (count != '0);
  assign do_push = push && !full;
  assign do_take = take && avail;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_take) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(do_push) - (AW+1)'(do_take);
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= (AW+1)'(DEPTH))
    else $error("frame queue count beyond depth");
  assert property (@(posedge clk) disable iff (rst) full |-> avail)
    else $error("full queue reports no frame");
  assert property (@(posedge clk) disable iff (rst)
      (do_push && !do_take) |=> count == $past(count) + 1'b1)
    else $error("frame queue count did not advance");

endmodule

FILE: hw/rtl/fpr_back.sv
// Back end: session scan, byte store and message emission sequencer.
module fpr_back import fpr_pkg::*; #(
  parameter int SESSIONS = 4,
  parameter int MAX_LEN  = 223
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        avail,
  output logic        take,
  input  frame_t      head,
  output logic        empty,
  input  logic        pop,
  output result_t     result
);

  localparam int SW    = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
  localparam int DEPTH = SESSIONS * MAX_LEN;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_WRITE, S_READ, S_EMIT, S_OUT
  } state_t;

  state_t           state;
  frame_t           f;
  logic [15:0]      timeout;
  logic [31:0]      drop_count;

  logic [SESSIONS-1:0] slot_busy;
  logic [7:0]       slot_source   [SESSIONS];
  logic [17:0]      slot_group    [SESSIONS];
  logic [2:0]       slot_sequence [SESSIONS];
  logic [7:0]       slot_total    [SESSIONS];
  logic [7:0]       slot_received [SESSIONS];
  logic [7:0]       slot_expected [SESSIONS];
  logic [31:0]      slot_touched  [SESSIONS];

  logic [7:0]       mem [DEPTH];
  logic [7:0]       rd_data;
  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  logic [AW-1:0]    mem_ra;
  logic [7:0]       mem_wd;

  logic [SW:0]      scan_i;
  logic [SW-1:0]    sel;
  logic             sel_ok;
  logic [7:0]       base_pos;
  logic [7:0]       pay;
  logic [3:0]       wr_k;
  logic [7:0]       total;
  logic [7:0]       rd_pos;
  logic [2:0]       rd_j;
  logic [4:0]       word_k;
  logic [63:0]      word_acc;
  logic             rd_pending;
  logic [AW-1:0]    slot_base;

  logic [3:0]       dlc;
  logic [2:0]       seq;
  logic [4:0]       ctr;
  logic [SW-1:0]    si;
  logic             hit;
  logic             stale;
  logic [7:0]       f_bytes [8];
  logic [7:0]       words;

  frame_t           head_c;
  logic [7:0]       room;
  logic [7:0]       pay_first;
  logic [7:0]       pay_next;
  logic             bad_len;
  logic             first_ok;
  logic             next_ok;
  logic             decide_ok;
  logic             decide_drop;

  assign dlc = (head.byte_count > 4'd8) ? 4'd8 : head.byte_count;
  assign seq = f.byte_0[7:5];
  assign ctr = f.byte_0[4:0];
  assign si  = scan_i[SW-1:0];
  assign hit = slot_busy[si] && slot_source[si] == f.src_addr &&
               slot_group[si] == f.group_number && slot_sequence[si] == seq;
  assign stale = slot_busy[si] && ((f.time_ms - slot_touched[si]) > {16'd0, timeout});
  assign f_bytes[0] = f.byte_0;
  assign f_bytes[1] = f.byte_1;
  assign f_bytes[2] = f.byte_2;
  assign f_bytes[3] = f.byte_3;
  assign f_bytes[4] = f.byte_4;
  assign f_bytes[5] = f.byte_5;
  assign f_bytes[6] = f.byte_6;
  assign f_bytes[7] = f.byte_7;
  assign words = (total + 8'd7) >> 3;
  assign slot_base = AW'(sel) * AW'(MAX_LEN);
  assign take = (state == S_IDLE) && avail && empty;

  always_comb begin
    head_c = head;
    head_c.byte_count = dlc;
  end

  assign room      = slot_total[sel] - slot_received[sel];
  assign pay_first = ({4'd0, f.byte_count} - 8'd2 > f.byte_1) ?
                     f.byte_1 : {4'd0, f.byte_count} - 8'd2;
  assign pay_next  = ({4'd0, f.byte_count} - 8'd1 > room) ?
                     room : {4'd0, f.byte_count} - 8'd1;
  assign bad_len   = (f.byte_1 == 8'd0) || (f.byte_1 > 8'(MAX_LEN));
  assign first_ok  = (ctr == 5'd0) && !bad_len;
  assign next_ok   = (ctr != 5'd0) && slot_busy[sel] && ({3'd0, ctr} == slot_expected[sel]) &&
                     (slot_received[sel] < slot_total[sel]);
  assign decide_ok = sel_ok && (first_ok || next_ok);
  assign decide_drop = !sel_ok || ((ctr == 5'd0) && bad_len) ||
                       ((ctr != 5'd0) && slot_busy[sel] && ({3'd0, ctr} != slot_expected[sel]));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout <= cfg_data;
    end
  end

  always_comb begin
    mem_we = (state == S_WRITE) && (wr_k < pay[3:0]);
    mem_wa = slot_base + AW'(base_pos) + AW'(wr_k);
    mem_wd = (ctr == 5'd0) ? f_bytes[3'(wr_k + 4'd2)] : f_bytes[3'(wr_k + 4'd1)];
    mem_ra = slot_base + AW'(rd_pos);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      empty      <= 1'b1;
      slot_busy  <= '0;
      drop_count <= '0;
      for (int i = 0; i < SESSIONS; i++) begin
        slot_source[i]   <= '0;
        slot_group[i]    <= '0;
        slot_sequence[i] <= '0;
        slot_total[i]    <= '0;
        slot_received[i] <= '0;
        slot_expected[i] <= '0;
        slot_touched[i]  <= '0;
      end
    end else begin
      if (!empty && pop) begin
        empty <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (take) begin
            f <= head_c;
            if (dlc < 4'd2) begin
              result <= '{ST_SHORT, 8'd0, 18'd0, 8'd0, 5'd0, 64'd0, 1'b1, drop_count};
              empty  <= 1'b0;
            end else begin
              scan_i  <= '0;
              sel_ok  <= 1'b0;
              state   <= S_SCAN;
            end
          end
        end
        // one slot per cycle; stop at the first busy match
        S_SCAN: begin
          if (hit) begin
            sel     <= si;
            sel_ok  <= 1'b1;
            state   <= S_DECIDE;
          end else begin
            if (!slot_busy[si] && !sel_ok) begin
              sel    <= si;
              sel_ok <= 1'b1;
            end
            if (stale) begin
              slot_busy[si] <= 1'b0;
              drop_count    <= drop_count + 1'b1;
              if (!sel_ok) begin
                sel    <= si;
                sel_ok <= 1'b1;
              end
            end
            if (scan_i == (SW+1)'(SESSIONS - 1)) begin
              state <= S_DECIDE;
            end
            scan_i <= scan_i + 1'b1;
          end
        end
        // decide: post a rejected result, or keep the result register empty while the payload is stored
        S_DECIDE: begin
          wr_k   <= '0;
          empty  <= decide_ok;
          state  <= decide_ok ? S_WRITE : S_IDLE;
          result <= '{ST_REJECTED, 8'd0, 18'd0, 8'd0, 5'd0, 64'd0, 1'b1,
                      drop_count + 32'(decide_drop)};
          if (decide_drop) begin
            drop_count <= drop_count + 1'b1;
          end
          if (sel_ok && !decide_ok) begin
            slot_busy[sel] <= 1'b0;
          end
          if (decide_ok && ctr == 5'd0) begin
            pay                <= pay_first;
            base_pos           <= '0;
            slot_busy[sel]     <= 1'b1;
            slot_source[sel]   <= f.src_addr;
            slot_group[sel]    <= f.group_number;
            slot_sequence[sel] <= seq;
            slot_total[sel]    <= f.byte_1;
            slot_expected[sel] <= 8'd1;
            slot_touched[sel]  <= f.time_ms;
            slot_received[sel] <= pay_first;
            total              <= f.byte_1;
          end
          if (decide_ok && ctr != 5'd0) begin
            pay                <= pay_next;
            base_pos           <= slot_received[sel];
            slot_received[sel] <= slot_received[sel] + pay_next;
            slot_expected[sel] <= slot_expected[sel] + 8'd1;
            slot_touched[sel]  <= f.time_ms;
            total              <= slot_total[sel];
          end
        end
        // copy payload bytes, one a cycle; then start the word read-out or report the message open
        S_WRITE: begin
          if (wr_k < pay[3:0]) begin
            wr_k <= wr_k + 1'b1;
          end else begin
            if (slot_received[sel] >= total) begin
              slot_busy[sel] <= 1'b0;
              rd_pos     <= '0;
              rd_j       <= '0;
              word_k     <= '0;
              word_acc   <= '0;
              rd_pending <= 1'b0;
              state      <= S_READ;
            end else begin
              result <= '{ST_OPEN, 8'd0, 18'd0, 8'd0, 5'd0, 64'd0, 1'b1, drop_count};
              empty  <= 1'b0;
              state  <= S_IDLE;
            end
          end
        end
        // gather a word byte by byte: a registered read in S_READ, then the capture in S_EMIT
        S_READ: begin
          rd_pending <= 1'b1;
          rd_pos     <= rd_pos + 8'd1;
          state      <= S_EMIT;
        end
        S_EMIT: begin
          if ({word_k, rd_j} < total) begin
            word_acc[rd_j*8 +: 8] <= rd_data;
          end
          if (rd_j == 3'd7) begin
            state <= S_OUT;
          end else begin
            rd_j  <= rd_j + 1'b1;
            state <= S_READ;
          end
        end
        S_OUT: begin
          if (empty) begin
            result <= '{ST_WORD, slot_source[sel], slot_group[sel], total, word_k,
                        word_acc, (8'(word_k) + 8'd1 == words), drop_count};
            empty <= 1'b0;
            word_acc <= '0;
            rd_j <= '0;
            if (8'(word_k) + 8'd1 == words) begin
              state <= S_IDLE;
            end else begin
              word_k <= word_k + 1'b1;
              state  <= S_READ;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) (state == S_WRITE) |-> sel_ok)
    else $error("byte copy without a session slot");
  assert property (@(posedge clk) disable iff (rst) take |-> empty)
    else $error("frame taken while a result waits");
  assert property (@(posedge clk) disable iff (rst) (state == S_EMIT) |-> rd_pending)
    else $error("word gathered before a read");

endmodule

FILE: hw/rtl/fast_packet_reassembler.sv
// Top level of the fast-packet reassembler.
// Takes CAN frames through a four-entry frame queue and rebuilds multi-frame
// fast-packet messages in a byte store of SESSIONS*MAX_LEN entries. A too-short
// frame gets a short result straight from idle. Any other frame is loaded, the slots are
// scanned (up to SESSIONS, fewer when the scan stops at a match) and the frame
// is decided on; a rejected frame ends there, an accepted one has its payload
// bytes copied in. A completing frame then has each 64-bit word read out as
// eight read-and-gather pairs on the single read port of the byte store and
// then loaded as a result. A new frame is taken only when the back end is idle
// and its last result has been popped. Every result is held until popped.
module fast_packet_reassembler import fpr_pkg::*; #(
  parameter int SESSIONS = 4,
  parameter int MAX_LEN  = 223
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  frame_t      frame,
  output logic        empty,
  input  logic        pop,
  output result_t     result
);

  logic   avail;
  logic   take;
  frame_t head;

  fpr_front #(.DEPTH(4)) u_front (
    .clk, .rst, .push, .full, .frame, .avail, .take, .head
  );

  fpr_back #(.SESSIONS(SESSIONS), .MAX_LEN(MAX_LEN)) u_back (
    .clk, .rst, .cfg_we, .cfg_data, .avail, .take, .head, .empty, .pop, .result
  );

endmodule
